[rtl/core/cft_pkg.sv]
// Shared types, constants and helpers for the CSV field tokenizer.
`default_nettype none

package cft_pkg;

  // Default depth of the field store
  localparam int FIELD_DEPTH_DEF = 32;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM = 2'd1;

  // Register reset values
  localparam logic [7:0] QUOTE_RST = 8'd34;
  localparam logic [7:0] DELIM_RST = 8'd44;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] COL_MAX   = 8'hFF;

  // Quoting state
  typedef enum logic [1:0] {
    QM_OUT,
    QM_IN,
    QM_SEEN
  } qmode_t;

  // Controller state
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_ONE
  } state_t;

  // Whitespace: space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

`default_nettype wire

[rtl/core/csv_field_tokenizer.sv]
// CSV field tokenizer: character scanner, field store and field emitter.
//
//   channel | direction | signals                                   | transaction
//   in      | input     | in_byte, in_byte_present, in_line_last    | one character or line end
//   out     | output    | out_byte, out_byte_valid, out_field_done, | one field byte or marker
//           |           | out_line_done, out_column_index,          |
//           |           | out_field_truncated                       |
//   cfg     | input     | cfg_index, cfg_data                       | one register write
//
// An item that yields no result leaves the controller idle. An item that ends a
// field is followed, for each trimmed byte, by a read of the field store and then
// a load of the output register (the store read is registered); an empty field
// or a line end marker goes through the one-result state instead.
// Reset is synchronous, active low; the field store is not cleared, since only
// entries below the fill count are ever read.
// A stalled output holds the emitter; the input is taken only while idle, even
// when a finished result still waits in the output register.
`default_nettype none

module csv_field_tokenizer #(
  parameter int FIELD_DEPTH = cft_pkg::FIELD_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input characters
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_byte,
  input  wire logic                         in_byte_present,
  input  wire logic                         in_line_last,
  // result bytes
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        out_byte,
  output logic                              out_byte_valid,
  output logic                              out_field_done,
  output logic                              out_line_done,
  output logic [7:0]                        out_column_index,
  output logic                              out_field_truncated,
  // configuration writes
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [cft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                   cfg_data
);

  import cft_pkg::*;

  localparam int AW = (FIELD_DEPTH > 1) ? $clog2(FIELD_DEPTH) : 1;
  localparam int CW = $clog2(FIELD_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(FIELD_DEPTH);

  // Configuration registers
  logic [7:0] quote_r;
  logic [7:0] delim_r;

  // Scanner state
  logic          esc_r, esc_nxt;
  qmode_t        qm_r, qm_nxt;
  logic          tok_r, tok_nxt;
  logic          skip_r, skip_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] first_r, first_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic          any_r, any_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    col_r, col_nxt;

  // Field store
  logic [7:0]    store_mem [FIELD_DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [7:0]    rd_data_r;

  // Emitter snapshot
  logic [AW-1:0] em_last_r, em_last_nxt;
  logic [7:0]    em_col_r, em_col_nxt;
  logic          em_trunc_r, em_trunc_nxt;
  logic          em_line_r, em_line_nxt;
  logic          em_fd_r, em_fd_nxt;
  logic [AW-1:0] em_first;
  logic          go_read;
  logic          go_one;

  // Controller
  state_t        state_r, state_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;

  // Output register
  logic          out_valid_r;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_bv_r, out_bv_nxt;
  logic          out_fd_r, out_fd_nxt;
  logic          out_ld_r, out_ld_nxt;
  logic [7:0]    out_col_r, out_col_nxt;
  logic          out_tr_r, out_tr_nxt;
  logic          load_out;
  logic          slot_free;
  logic          in_acc;
  logic          ptr_done;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_ready;
  assign ptr_done  = (rd_ptr_r == em_last_r);

  assign out_valid           = out_valid_r;
  assign out_byte            = out_byte_r;
  assign out_byte_valid      = out_bv_r;
  assign out_field_done      = out_fd_r;
  assign out_line_done       = out_ld_r;
  assign out_column_index    = out_col_r;
  assign out_field_truncated = out_tr_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= QUOTE_RST;
      delim_r <= DELIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_QUOTE) quote_r <= cfg_data;
      if (cfg_index == CFG_DELIM) delim_r <= cfg_data;
    end
  end

  // Scanner: next state for one accepted character
  always_comb begin
    logic         hit;
    logic         do_app;
    logic         do_delim;
    logic [7:0]   app_b;
    logic [7:0]   c;
    c        = in_byte;
    hit      = 1'b0;
    do_app   = 1'b0;
    do_delim = 1'b0;
    app_b    = c;

    esc_nxt  = esc_r;
    qm_nxt   = qm_r;
    tok_nxt  = tok_r;
    skip_nxt = skip_r;
    fill_nxt = fill_r;
    first_nxt = first_r;
    last_nxt = last_r;
    any_nxt  = any_r;
    ovf_nxt  = ovf_r;
    col_nxt  = col_r;
    wr_en    = 1'b0;
    wr_addr  = fill_r[AW-1:0];
    wr_data  = app_b;

    em_first     = first_r;
    em_last_nxt  = last_r;
    em_col_nxt   = col_r;
    em_trunc_nxt = ovf_r;
    em_line_nxt  = in_line_last;
    em_fd_nxt    = 1'b1;
    go_read      = 1'b0;
    go_one       = 1'b0;

    // character classification
    if (in_byte_present && !(skip_r && is_ws(c))) begin
      skip_nxt = 1'b0;
      if (qm_r == QM_SEEN) begin
        if (c == quote_r) begin
          do_app  = 1'b1;
          tok_nxt = 1'b1;
          qm_nxt  = QM_IN;
          hit     = 1'b1;
        end else begin
          qm_nxt = QM_OUT;
        end
      end
      if (!hit) begin
        priority if (!esc_r && c == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (esc_r) begin
          if (c == CH_N)      app_b = CH_NL;
          else if (c == CH_T) app_b = CH_TAB;
          do_app  = 1'b1;
          tok_nxt = 1'b1;
          esc_nxt = 1'b0;
        end else if (qm_nxt == QM_OUT && fill_r == '0 && quote_r != 8'd0
                     && c == quote_r) begin
          qm_nxt  = QM_IN;
          tok_nxt = 1'b1;
        end else if (qm_nxt == QM_IN && c == quote_r) begin
          qm_nxt = QM_SEEN;
        end else if (qm_nxt == QM_OUT && c == delim_r) begin
          do_delim = 1'b1;
        end else begin
          do_app  = 1'b1;
          tok_nxt = 1'b1;
        end
      end
    end

    // append into the field store, tracking the trim window
    wr_data = app_b;
    if (do_app) begin
      if (fill_r < DEPTH_C) begin
        wr_en = 1'b1;
        if (!is_ws(app_b)) begin
          if (!any_r) first_nxt = fill_r[AW-1:0];
          last_nxt = fill_r[AW-1:0];
          any_nxt  = 1'b1;
        end
        fill_nxt = fill_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    // field end: delimiter, or line end with a token under way
    if (do_delim || (in_line_last && tok_nxt)) begin
      em_first     = first_nxt;
      em_last_nxt  = last_nxt;
      em_trunc_nxt = ovf_nxt;
      em_col_nxt   = col_r;
      em_fd_nxt    = 1'b1;
      go_read      = any_nxt;
      go_one       = !any_nxt;
    end else if (in_line_last) begin
      // line end marker
      em_trunc_nxt = 1'b0;
      em_fd_nxt    = 1'b0;
      go_one       = 1'b1;
    end

    if (do_delim) begin
      if (col_r != COL_MAX) col_nxt = col_r + 8'd1;
      skip_nxt = 1'b1;
    end
    if (do_delim || in_line_last) begin
      fill_nxt  = '0;
      first_nxt = '0;
      last_nxt  = '0;
      any_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
      tok_nxt   = 1'b0;
    end
    if (in_line_last) begin
      esc_nxt  = 1'b0;
      qm_nxt   = QM_OUT;
      skip_nxt = 1'b0;
      col_nxt  = 8'd0;
    end
  end

  // Scanner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r   <= 1'b0;
      qm_r    <= QM_OUT;
      tok_r   <= 1'b0;
      skip_r  <= 1'b0;
      fill_r  <= '0;
      first_r <= '0;
      last_r  <= '0;
      any_r   <= 1'b0;
      ovf_r   <= 1'b0;
      col_r   <= 8'd0;
    end else if (in_acc) begin
      esc_r   <= esc_nxt;
      qm_r    <= qm_nxt;
      tok_r   <= tok_nxt;
      skip_r  <= skip_nxt;
      fill_r  <= fill_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      any_r   <= any_nxt;
      ovf_r   <= ovf_nxt;
      col_r   <= col_nxt;
    end
  end

  // Emitter snapshot, taken on every accepted transaction; used when it ends a field or a line
  always_ff @(posedge clk) begin
    if (in_acc) begin
      em_last_r  <= em_last_nxt;
      em_col_r   <= em_col_nxt;
      em_trunc_r <= em_trunc_nxt;
      em_line_r  <= em_line_nxt;
      em_fd_r    <= em_fd_nxt;
    end
  end

  // Field store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && wr_en) store_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= store_mem[rd_ptr_r];
  end

  // Controller: next state and output loads
  always_comb begin
    state_nxt    = state_r;
    rd_ptr_nxt   = rd_ptr_r;
    rd_en        = 1'b0;
    load_out     = 1'b0;
    out_byte_nxt = 8'd0;
    out_bv_nxt   = 1'b0;
    out_fd_nxt   = em_fd_r;
    out_ld_nxt   = em_line_r;
    out_col_nxt  = em_col_r;
    out_tr_nxt   = em_trunc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rd_ptr_nxt = em_first;
          if (go_read)     state_nxt = ST_READ;
          else if (go_one) state_nxt = ST_ONE;
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        out_byte_nxt = rd_data_r;
        out_bv_nxt   = 1'b1;
        out_fd_nxt   = ptr_done;
        out_ld_nxt   = ptr_done && em_line_r;
        if (slot_free) begin
          load_out = 1'b1;
          if (ptr_done) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_ptr_nxt = rd_ptr_r + 1'b1;
            state_nxt  = ST_READ;
          end
        end
      end
      ST_ONE: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_ptr_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte_r <= out_byte_nxt;
      out_bv_r   <= out_bv_nxt;
      out_fd_r   <= out_fd_nxt;
      out_ld_r   <= out_ld_nxt;
      out_col_r  <= out_col_nxt;
      out_tr_r   <= out_tr_nxt;
    end
  end

  // Fill count never passes the store depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("fill count beyond field store depth");

  // Trim window lies inside the filled part of the store
  a_trim_window: assert property (@(posedge clk) disable iff (!rst_n)
    any_r |-> (first_r <= last_r) && ({1'b0, last_r} < {1'b0, fill_r}))
    else $error("trim window outside filled entries");

  // Emitter never reads past the last kept byte
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_LOAD) |-> rd_ptr_r <= em_last_r)
    else $error("read pointer past end of field");

  // Line end returns per-line state to its reset values
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_line_last) |=> (col_r == 8'd0 && fill_r == '0 && qm_r == QM_OUT
                                  && !esc_r && !tok_r))
    else $error("per-line state not cleared at line end");

  // A loaded result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

endmodule

`default_nettype wire

[sim/csv_field_tokenizer_checker.sv]
// Result checker for the CSV field tokenizer: predicts and compares result transactions.

module csv_field_tokenizer_checker #(
  parameter int FIELD_DEPTH = cft_pkg::FIELD_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          in_byte_present,
  input  logic                          in_line_last,
  // result channel
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [7:0]                    out_byte,
  input  logic                          out_byte_valid,
  input  logic                          out_field_done,
  input  logic                          out_line_done,
  input  logic [7:0]                    out_column_index,
  input  logic                          out_field_truncated,
  // configuration channel
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  // status to the bench
  output int                            fail_count,
  output int                            pending
);

  import cft_pkg::*;

  typedef struct packed {
    logic [7:0] chr;
    logic       chr_ok;
    logic       fld_end;
    logic       ln_end;
    logic [7:0] col_idx;
    logic       trunc;
  } tok_result_t;

  // Expected result transactions, oldest first
  tok_result_t field_bytes_due[$];

  int mism_count = 0;
  int pend_count = 0;

  assign fail_count = mism_count;
  assign pending    = pend_count;

  // Shadow registers and scanner state
  logic [7:0] quote_r;
  logic [7:0] delim_r;
  logic       esc_pend;
  qmode_t     qmode;
  logic       tok_pend;
  logic       skip_ws;
  logic [7:0] fld_mem [FIELD_DEPTH];
  int         fill;
  int         first_ns;
  int         last_ns;
  logic       seen_ns;
  logic       ovf;
  logic [7:0] col;

  function automatic logic blank(input logic [7:0] c);
    case (c)
      8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_field();
    fill     = 0;
    first_ns = 0;
    last_ns  = 0;
    seen_ns  = 1'b0;
    ovf      = 1'b0;
    tok_pend = 1'b0;
  endfunction

  // Store a byte, tracking the nonblank span for trimming
  function automatic void store_byte(input logic [7:0] c);
    if (fill < FIELD_DEPTH) begin
      fld_mem[fill] = c;
      if (!blank(c)) begin
        if (!seen_ns) first_ns = fill;
        last_ns = fill;
        seen_ns = 1'b1;
      end
      fill++;
    end else begin
      ovf = 1'b1;
    end
  endfunction

  function automatic void push_result(input logic [7:0] chr, input logic ok,
                                      input logic fe, input logic le);
    tok_result_t r;
    r.chr     = chr;
    r.chr_ok  = ok;
    r.fld_end = fe;
    r.ln_end  = le;
    r.col_idx = col;
    r.trunc   = ovf;
    field_bytes_due = {field_bytes_due, r};
  endfunction

  // Trimmed field, or a single empty-field transaction
  function automatic void emit_field();
    if (!seen_ns) begin
      push_result(8'h00, 1'b0, 1'b1, 1'b0);
    end else begin
      for (int i = first_ns; i <= last_ns; i++)
        push_result(fld_mem[i], 1'b1, i == last_ns, 1'b0);
    end
  endfunction

  function automatic void take_char(input logic [7:0] c);
    // quote seen inside quotes: doubled quote or close
    if (qmode == QM_SEEN) begin
      if (c == quote_r) begin
        store_byte(c);
        tok_pend = 1'b1;
        qmode = QM_IN;
        return;
      end
      qmode = QM_OUT;
    end
    if (!esc_pend && c == CH_BSLASH) begin
      esc_pend = 1'b1;
      return;
    end
    if (esc_pend) begin
      if (c == CH_N) store_byte(CH_NL);
      else if (c == CH_T) store_byte(CH_TAB);
      else store_byte(c);
      tok_pend = 1'b1;
      esc_pend = 1'b0;
      return;
    end
    // opening quote only at the start of an empty field
    if (qmode == QM_OUT && fill == 0 && quote_r != 8'h00 && c == quote_r) begin
      qmode = QM_IN;
      tok_pend = 1'b1;
      return;
    end
    if (qmode == QM_IN && c == quote_r) begin
      qmode = QM_SEEN;
      return;
    end
    if (qmode == QM_OUT && c == delim_r) begin
      emit_field();
      clear_field();
      if (col != COL_MAX) col++;
      skip_ws = 1'b1;
      return;
    end
    store_byte(c);
    tok_pend = 1'b1;
  endfunction

  // Expected results of one accepted input transaction
  function automatic void tokenize_item(input logic [7:0] c, input logic pres,
                                        input logic last);
    int base;
    tok_result_t r;
    base = field_bytes_due.size();
    if (pres) begin
      if (!(skip_ws && blank(c))) begin
        skip_ws = 1'b0;
        take_char(c);
      end
    end
    if (last) begin
      esc_pend = 1'b0;
      if (tok_pend) emit_field();
      if (field_bytes_due.size() == base) begin
        push_result(8'h00, 1'b0, 1'b0, 1'b1);
      end else begin
        r = field_bytes_due.pop_back();
        r.ln_end = 1'b1;
        field_bytes_due = {field_bytes_due, r};
      end
      qmode = QM_OUT;
      skip_ws = 1'b0;
      clear_field();
      col = '0;
    end
  endfunction

  function automatic void check_field_byte();
    tok_result_t want;
    if (field_bytes_due.size() == 0) begin
      mism_count++;
      if (mism_count <= 10)
        $display("%0t: result with none expected: byte %02h vld %b fd %b ld %b col %0d trunc %b",
                 $time, out_byte, out_byte_valid, out_field_done, out_line_done,
                 out_column_index, out_field_truncated);
      return;
    end
    want = field_bytes_due.pop_front();
    if (out_byte !== want.chr || out_byte_valid !== want.chr_ok ||
        out_field_done !== want.fld_end || out_line_done !== want.ln_end ||
        out_column_index !== want.col_idx || out_field_truncated !== want.trunc) begin
      mism_count++;
      if (mism_count <= 10) begin
        $display("%0t: mismatch, expected byte %02h vld %b fd %b ld %b col %0d trunc %b",
                 $time, want.chr, want.chr_ok, want.fld_end, want.ln_end,
                 want.col_idx, want.trunc);
        $display("%0t:           actual byte %02h vld %b fd %b ld %b col %0d trunc %b",
                 $time, out_byte, out_byte_valid, out_field_done, out_line_done,
                 out_column_index, out_field_truncated);
      end
    end
  endfunction

  // Results of an accepted input show up at a later edge, so compare first
  always @(posedge clk) begin
    if (!rst_n) begin
      quote_r  = QUOTE_RST;
      delim_r  = DELIM_RST;
      esc_pend = 1'b0;
      qmode    = QM_OUT;
      skip_ws  = 1'b0;
      clear_field();
      col      = '0;
      field_bytes_due.delete();
    end else begin
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_QUOTE) quote_r = cfg_data;
        else if (cfg_index == CFG_DELIM) delim_r = cfg_data;
      end
      if (out_valid && out_ready) check_field_byte();
      if (in_valid && in_ready) tokenize_item(in_byte, in_byte_present, in_line_last);
    end
    pend_count = field_bytes_due.size();
  end

endmodule

[sim/csv_field_tokenizer_tb.sv]
// Testbench top for the CSV field tokenizer: stimulus, flow control and verdict.

module csv_field_tokenizer_tb;

  import cft_pkg::*;

  localparam int RUN_LIMIT     = 600000;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 10;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_byte;
  logic                 in_byte_present;
  logic                 in_line_last;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_byte;
  logic                 out_byte_valid;
  logic                 out_field_done;
  logic                 out_line_done;
  logic [7:0]           out_column_index;
  logic                 out_field_truncated;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  int fail_count;
  int pending;

  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  bit         hold_req      = 1'b0;
  int         items_sent    = 0;
  logic [7:0] cur_quote     = QUOTE_RST;
  logic [7:0] cur_delim     = DELIM_RST;
  logic [7:0] line_buf[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  csv_field_tokenizer DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte             (in_byte),
    .in_byte_present     (in_byte_present),
    .in_line_last        (in_line_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_byte_valid      (out_byte_valid),
    .out_field_done      (out_field_done),
    .out_line_done       (out_line_done),
    .out_column_index    (out_column_index),
    .out_field_truncated (out_field_truncated),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  csv_field_tokenizer_checker tok_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte             (in_byte),
    .in_byte_present     (in_byte_present),
    .in_line_last        (in_line_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_byte_valid      (out_byte_valid),
    .out_field_done      (out_field_done),
    .out_line_done       (out_line_done),
    .out_column_index    (out_column_index),
    .out_field_truncated (out_field_truncated),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    repeat (RUN_LIMIT) @(posedge clk);
    $display("csv_field_tokenizer_tb: FAIL");
    $finish;
  end

  // One input transaction; valid stays up afterwards until the next negedge
  task automatic offer_char(input logic [7:0] c, input logic pres, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_byte         <= c;
    in_byte_present <= pres;
    in_line_last    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (pres || last) items_sent++;
  endtask

  // Drop valid, wait for all expected results and let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_QUOTE) cur_quote = data;
    else if (idx == CFG_DELIM) cur_delim = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] blank_pick();
    case ($urandom_range(5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NL;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return CH_CR;
    endcase
  endfunction

  // Mostly printable characters that carry no special meaning
  function automatic logic [7:0] text_pick();
    logic [7:0] c;
    if ($urandom_range(9) < 3) begin
      c = 8'($urandom_range(255));
      return c;
    end
    do begin
      c = 8'($urandom_range(8'h21, 8'h7E));
    end while (c == cur_quote || c == cur_delim || c == CH_BSLASH);
    return c;
  endfunction

  function automatic void add_escape();
    line_buf = {line_buf, CH_BSLASH};
    case ($urandom_range(4))
      0: line_buf = {line_buf, CH_N};
      1: line_buf = {line_buf, CH_T};
      2: line_buf = {line_buf, cur_quote};
      3: line_buf = {line_buf, CH_BSLASH};
      default: line_buf = {line_buf, text_pick()};
    endcase
  endfunction

  // One field: padding, optional quoting, escapes, doubled quotes; long ones may overflow
  function automatic void add_field();
    int  len;
    int  r;
    bit  quoted;
    quoted = ($urandom_range(2) == 0);
    len = ($urandom_range(9) == 0) ? $urandom_range(28, 40) : $urandom_range(6);
    if (!quoted || $urandom_range(2) == 0)
      repeat ($urandom_range(2)) line_buf = {line_buf, blank_pick()};
    if (quoted) line_buf = {line_buf, cur_quote};
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 8) begin
        add_escape();
      end else if (quoted && r < 14) begin
        line_buf = {line_buf, cur_quote};
        line_buf = {line_buf, cur_quote};
      end else if (quoted && r < 18) begin
        line_buf = {line_buf, cur_delim};
      end else if (r < 26) begin
        line_buf = {line_buf, blank_pick()};
      end else begin
        line_buf = {line_buf, text_pick()};
      end
    end
    // now and then leave the quote open
    if (quoted && $urandom_range(9) != 0) line_buf = {line_buf, cur_quote};
    repeat ($urandom_range(2)) line_buf = {line_buf, blank_pick()};
  endfunction

  function automatic void compose_line();
    int nf;
    nf = $urandom_range(1, 5);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) line_buf = {line_buf, cur_delim};
      add_field();
    end
    if ($urandom_range(9) == 0) line_buf = {line_buf, cur_delim};
    if ($urandom_range(19) == 0) line_buf = {line_buf, CH_BSLASH};
  endfunction

  // Send the composed line; the end rides on the last char or a bare transaction
  task automatic send_line();
    int n;
    bit bare_end;
    n = line_buf.size();
    bare_end = (n == 0) || ($urandom_range(5) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(29) == 0) offer_char(8'($urandom_range(255)), 1'b0, 1'b0);
      offer_char(line_buf[i], 1'b1, !bare_end && i == n - 1);
    end
    if (bare_end) offer_char(8'($urandom_range(255)), 1'b0, 1'b1);
    line_buf.delete();
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++)
      offer_char(8'($urandom_range(255)), 1'($urandom_range(1)), i == len - 1);
  endtask

  initial begin : stimulus
    logic [7:0] q;
    logic [7:0] d;
    int         goal;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_byte         = 8'h00;
    in_byte_present = 1'b0;
    in_line_last    = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_QUOTE;
    cfg_data        = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed lines at reset register values
    // quoted field with doubled quote and escaped n, skipped padding, escaped
    // other char, trailing delimiter, ignored bare item, bare line end
    offer_char(cur_quote, 1'b1, 1'b0);
    offer_char("a", 1'b1, 1'b0);
    offer_char(cur_quote, 1'b1, 1'b0);
    offer_char(cur_quote, 1'b1, 1'b0);
    offer_char(CH_BSLASH, 1'b1, 1'b0);
    offer_char(CH_N, 1'b1, 1'b0);
    offer_char(cur_quote, 1'b1, 1'b0);
    offer_char(cur_delim, 1'b1, 1'b0);
    offer_char(CH_SPACE, 1'b1, 1'b0);
    offer_char(8'hFF, 1'b1, 1'b0);
    offer_char(CH_BSLASH, 1'b1, 1'b0);
    offer_char("q", 1'b1, 1'b0);
    offer_char(CH_SPACE, 1'b1, 1'b0);
    offer_char(cur_delim, 1'b1, 1'b0);
    offer_char(8'h00, 1'b0, 1'b0);
    offer_char(8'hFF, 1'b0, 1'b1);
    // empty line
    offer_char(8'h00, 1'b0, 1'b1);
    // line end with an escape pending
    offer_char("x", 1'b1, 1'b0);
    offer_char(8'h00, 1'b1, 1'b0);
    offer_char(CH_BSLASH, 1'b1, 1'b1);
    // line end right on the closing quote
    offer_char(cur_quote, 1'b1, 1'b0);
    offer_char("b", 1'b1, 1'b0);
    offer_char(cur_quote, 1'b1, 1'b1);
    // escaped t and trimming
    offer_char(CH_SPACE, 1'b1, 1'b0);
    offer_char(CH_T, 1'b1, 1'b0);
    offer_char(CH_BSLASH, 1'b1, 1'b0);
    offer_char(CH_T, 1'b1, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin q = 8'd34;  d = 8'd44; end
        1:       begin q = 8'd39;  d = 8'd59; end
        2:       begin q = 8'd0;   d = CH_TAB; end
        3:       begin q = 8'd255; d = 8'd0;  end
        4:       begin q = CH_BSLASH; d = CH_BSLASH; end
        default: begin q = 8'd44;  d = 8'd44; end
      endcase

      // quote char changed while a quoted field is open
      if (ph == 1) begin
        offer_char(cur_quote, 1'b1, 1'b0);
        offer_char("c", 1'b1, 1'b0);
        settle();
        write_reg(CFG_QUOTE, q);
        offer_char(cur_quote, 1'b1, 1'b0);
        offer_char(cur_delim, 1'b1, 1'b0);
        offer_char("d", 1'b1, 1'b1);
      end

      settle();
      write_reg(CFG_QUOTE, q);
      write_reg(CFG_DELIM, d);
      if (ph == 3) write_reg(CFG_SPARE, 8'hA5);

      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 78; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 8;  stall_pct = 8;  end
      endcase

      if (ph == 0) begin
        // long receiver hold-off while lines keep coming
        hold_req = 1'b1;
      end

      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        if ($urandom_range(9) < 2) begin
          send_noise();
        end else begin
          compose_line();
          send_line();
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("csv_field_tokenizer_tb: PASS");
    end else begin
      $display("csv_field_tokenizer_tb: FAIL");
    end
    $finish;
  end

endmodule
